// ===== design/assert_macros.svh =====
// Assertion macros shared by checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, off during reset.
`define CHK_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Next-cycle implication.
`define CHK_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// ===== design/sha256_pkg.sv =====
// Types and constants for the SHA-256 byte stream hasher.
// No dependencies.
package sha256_pkg;
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} out_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_ADD   = 7'b0001000,
		ST_PAD   = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_WAIT  = 7'b1000000
	} state_t;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
endpackage

// ===== design/sha256_in_if.sv =====
// Input channel interface: valid/ready with one message byte item.
// Depends on sha256_pkg.
interface sha256_in_if;
	logic valid;
	logic ready;
	sha256_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/sha256_out_if.sv =====
// Output channel interface: valid/ready with one digest word item.
// Depends on sha256_pkg.
interface sha256_out_if;
	logic valid;
	logic ready;
	sha256_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/sha256_round.sv =====
// One SHA-256 compression round, combinational.
// Depends on sha256_pkg.
module sha256_round (
	input  logic [31:0] vin [8],
	input  logic [31:0] k,
	input  logic [31:0] w,
	output logic [31:0] vout [8]
);
	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	logic [31:0] t1, t2, e, a;

	always_comb begin
		e = vin[4];
		a = vin[0];
		t1 = vin[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
			+ ((e & vin[5]) ^ (~e & vin[6])) + k + w;
		t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
			+ ((a & vin[1]) ^ (a & vin[2]) ^ (vin[1] & vin[2]));
		vout[7] = vin[6];
		vout[6] = vin[5];
		vout[5] = vin[4];
		vout[4] = vin[3] + t1;
		vout[3] = vin[2];
		vout[2] = vin[1];
		vout[1] = vin[0];
		vout[0] = t1 + t2;
	end
endmodule

// ===== design/sha256_byte_stream_hasher_top.sv =====
// Top level of the SHA-256 byte stream hasher: byte buffer memory, schedule
// window, round sequencer, padding and digest output. Depends on sha256_pkg,
// sha256_in_if, sha256_out_if and sha256_round.
//
//   channel  | dir | payload                                   | handshake
//   in_ch    | in  | msg_byte, byte_present, end_of_message    | valid/ready
//   out_ch   | out | digest_word, word_number, last_word       | valid/ready
//
// A byte transaction is taken in the cycle it is offered while idle.
// A block that is complete stalls the input while its 64 bytes are read from the
// buffer memory, the last read is awaited, 64 rounds run and one chain add is made.
// End of message pads the block from pos on and compresses it, plus one more pad
// block and compression if the length no longer fits or the last byte filled the block.
// Then eight output transactions follow, at most one per cycle.
// arst_n clears control state; the memories hold no reset contents.
// A stalled output holds its word; no input is taken until the digest is out.
module sha256_byte_stream_hasher_top (
	input logic clk,
	input logic arst_n,
	sha256_in_if.sink in_ch,
	sha256_out_if.source out_ch
);
	// byte buffer: 64 x 8, written by byte input or padding, read during load
	logic [7:0]  buf_mem [64];
	logic [7:0]  buf_rd_s1;
	// schedule window: 16 words kept in flops (fixed expansion taps, indexed read in rounds 0..15)
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] vnext [8];
	logic [31:0] h_q [8];
	logic [63:0] count_q;
	logic [5:0]  idx_q;       // load byte index / round counter / pad position
	logic [2:0]  out_idx_q;
	logic        final_q;     // compression belongs to padding
	logic        second_q;    // another padded block follows
	logic        rd_vld_s1;
	logic [5:0]  rd_addr_s1;
	sha256_pkg::state_t state_q;

	logic [31:0] w_cur, w_new;
	logic [31:0] x2, x15;
	logic [31:0] s0, s1;
	logic [63:0] bits;

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	sha256_round u_round (.vin(v_q), .k(sha256_pkg::ROUND_K[idx_q]), .w(w_cur), .vout(vnext));

	// expansion: window taps at fixed places, w_q[0] is oldest
	always_comb begin
		x2  = w_q[14];
		x15 = w_q[1];
		s1 = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
		s0 = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = (idx_q < 6'd16) ? w_q[idx_q[3:0]] : w_new;
		bits = {count_q[60:0], 3'b000};
	end

	assign in_ch.ready = (state_q == sha256_pkg::ST_IDLE);
	assign out_ch.valid = (state_q == sha256_pkg::ST_EMIT);
	assign out_ch.data.digest_word = h_q[out_idx_q];
	assign out_ch.data.word_number = out_idx_q;
	assign out_ch.data.last_word = (out_idx_q == 3'd7);

	// buffer memory write and registered read
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [7:0]  wr_data;
	logic [5:0]  pad_pos;
	always_comb begin
		wr_en = 1'b0;
		wr_addr = count_q[5:0];
		wr_data = in_ch.data.msg_byte;
		pad_pos = idx_q;
		if (state_q == sha256_pkg::ST_IDLE && in_ch.valid && in_ch.data.byte_present) begin
			wr_en = 1'b1;
		end else if (state_q == sha256_pkg::ST_PAD) begin
			wr_en = 1'b1;
			wr_addr = pad_pos;
			if (!second_q && pad_pos >= 6'd56) begin
				// length big-endian: byte 56 takes bits 63..56
				wr_data = bits[{~pad_pos[2:0], 3'b111} -: 8];
			end else if (pad_pos == count_q[5:0] && !final_q) begin
				wr_data = sha256_pkg::PAD_MARK;
			end else begin
				wr_data = 8'h00;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[wr_addr] <= wr_data;
		end
		buf_rd_s1 <= buf_mem[idx_q];
		rd_addr_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			out_idx_q <= '0;
			final_q <= 1'b0;
			second_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::INIT_H[i];
		end else begin
			rd_vld_s1 <= (state_q == sha256_pkg::ST_LOAD);
			case (state_q)
				sha256_pkg::ST_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.data.byte_present) begin
							count_q <= count_q + 64'd1;
						end
						if (in_ch.data.byte_present && count_q[5:0] == 6'd63) begin
							// block complete: compress, then a fresh pad block if end follows
							final_q <= 1'b0;
							second_q <= in_ch.data.end_of_message;
							idx_q <= '0;
							state_q <= sha256_pkg::ST_LOAD;
						end else if (in_ch.data.end_of_message) begin
							idx_q <= in_ch.data.byte_present ? count_q[5:0] + 6'd1 : count_q[5:0];
							final_q <= 1'b0;
							second_q <= ((in_ch.data.byte_present ? count_q[5:0] + 6'd1
								: count_q[5:0]) >= 6'd56);
							state_q <= sha256_pkg::ST_PAD;
						end
					end
				end
				sha256_pkg::ST_PAD: begin
					// final_q used here as "mark already written"
					final_q <= 1'b1;
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) begin
						idx_q <= '0;
						state_q <= sha256_pkg::ST_LOAD;
					end
				end
				sha256_pkg::ST_LOAD: begin
					idx_q <= idx_q + 6'd1;
					if (rd_vld_s1) begin
						w_q[rd_addr_s1[5:2]] <= {w_q[rd_addr_s1[5:2]][23:0], buf_rd_s1};
					end
					if (idx_q == 6'd63) begin
						state_q <= sha256_pkg::ST_WAIT;
					end
				end
				sha256_pkg::ST_WAIT: begin
					w_q[rd_addr_s1[5:2]] <= {w_q[rd_addr_s1[5:2]][23:0], buf_rd_s1};
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					idx_q <= '0;
					state_q <= sha256_pkg::ST_ROUND;
				end
				sha256_pkg::ST_ROUND: begin
					v_q <= vnext;
					if (idx_q >= 6'd16) begin
						for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
						w_q[15] <= w_new;
					end else if (idx_q == 6'd15) begin
						// window now in order, oldest first
					end
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) state_q <= sha256_pkg::ST_ADD;
				end
				sha256_pkg::ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					idx_q <= '0;
					if (second_q) begin
						second_q <= 1'b0;
						state_q <= sha256_pkg::ST_PAD;
					end else if (final_q) begin
						out_idx_q <= '0;
						state_q <= sha256_pkg::ST_EMIT;
					end else begin
						state_q <= sha256_pkg::ST_IDLE;
					end
				end
				sha256_pkg::ST_EMIT: begin
					if (out_ch.ready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::INIT_H[i];
							count_q <= '0;
							final_q <= 1'b0;
							state_q <= sha256_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= sha256_pkg::ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/sha256_checker.sv =====
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  word_number,
	input logic        last_word
);
	`CHK_IMP(a_excl, clk, arst_n, out_valid, !in_ready)
	`CHK_IMP(a_last, clk, arst_n, out_valid, last_word == (word_number == 3'd7))
	`CHK_NXT(a_step, clk, arst_n, out_valid && out_ready && !last_word,
		out_valid && word_number == $past(word_number) + 3'd1)
	`CHK_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(word_number))
endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .word_number(out_ch.data.word_number),
	.last_word(out_ch.data.last_word));
